FILE: hw/rtl/ata_pkg.sv
package ata_pkg;

	localparam int SampleW = 16;
	localparam int SumW = 24;
	localparam int CntW = 8;
	localparam int AngW = 16;
	localparam int FracBits = 8;
	localparam int CordicSteps = 16;
	localparam int TabFrac = 24;
	localparam int TabLen = 24;
	localparam int RootW = 33;
	localparam int CxW = 40;
	localparam int AccW = 32;
	localparam logic [CntW-1:0] CountReset = 8'd10;
	localparam logic [AngW-1:0] FullAngle = 16'(90 << FracBits);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQ,
		ST_ROOT,
		ST_CORD,
		ST_DONE
	} ata_state_t;

	// CORDIC run control between the sequencer and the angle unit
	typedef struct packed {
		logic start;
		logic [RootW-1:0] num;
		logic [RootW-1:0] den;
		logic neg;
	} ata_cord_req_t;

	function automatic logic [AccW-1:0] atan_tab(input logic [4:0] i);
		logic [AccW-1:0] v;
		begin
			unique case (i)
				5'd0: v = 32'd754974720;
				5'd1: v = 32'd445687602;
				5'd2: v = 32'd235489089;
				5'd3: v = 32'd119537938;
				5'd4: v = 32'd60000934;
				5'd5: v = 32'd30029717;
				5'd6: v = 32'd15018523;
				5'd7: v = 32'd7509719;
				5'd8: v = 32'd3754917;
				5'd9: v = 32'd1877466;
				5'd10: v = 32'd938734;
				5'd11: v = 32'd469367;
				5'd12: v = 32'd234684;
				5'd13: v = 32'd117342;
				5'd14: v = 32'd58671;
				5'd15: v = 32'd29335;
				5'd16: v = 32'd14668;
				5'd17: v = 32'd7334;
				5'd18: v = 32'd3667;
				5'd19: v = 32'd1833;
				5'd20: v = 32'd917;
				5'd21: v = 32'd458;
				5'd22: v = 32'd229;
				5'd23: v = 32'd115;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

FILE: hw/rtl/ata_cordic.sv
module ata_cordic (
	input logic clk,
	input logic arst_n,
	input ata_pkg::ata_cord_req_t req,
	output logic done,
	output logic [ata_pkg::AngW-1:0] angle
);
	import ata_pkg::*;

	logic busy_q;
	logic [4:0] step_q;
	logic signed [CxW-1:0] cx_q, cy_q;
	logic signed [AccW+1:0] acc_q;
	logic neg_q, done_q;
	logic [AngW-1:0] angle_q;
	logic signed [CxW-1:0] sx, sy;
	logic signed [AccW+1:0] rnd;
	logic [AngW-1:0] mag;

	assign sx = cx_q >>> step_q;
	assign sy = cy_q >>> step_q;

	// round the Q24 angle and clamp to the first quadrant
	always_comb begin
		rnd = (acc_q + (AccW+2)'(1 << (TabFrac - FracBits - 1))) >>> (TabFrac - FracBits);
		if (rnd < 0) mag = '0;
		else if (rnd > (AccW+2)'(FullAngle)) mag = FullAngle;
		else mag = rnd[AngW-1:0];
	end

	// iterate one vectoring step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				neg_q <= req.neg;
				step_q <= '0;
				acc_q <= '0;
				cx_q <= CxW'(req.den);
				cy_q <= CxW'(req.num);
				if (req.num == '0) begin
					angle_q <= '0;
					done_q <= 1'b1;
				end else if (req.den == '0) begin
					angle_q <= req.neg ? AngW'(-FullAngle) : FullAngle;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (32'(step_q) == CordicSteps || cy_q == 0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					angle_q <= neg_q ? AngW'(-mag) : mag;
				end else begin
					if (cy_q > 0) begin
						cx_q <= cx_q + sy;
						cy_q <= cy_q - sx;
						acc_q <= acc_q + (AccW+2)'(atan_tab(step_q));
					end else begin
						cx_q <= cx_q - sy;
						cy_q <= cy_q + sx;
						acc_q <= acc_q - (AccW+2)'(atan_tab(step_q));
					end
					step_q <= step_q + 5'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign angle = angle_q;
endmodule

FILE: hw/rtl/accel_tilt_angle_averager_top.sv
// A non-final sample is only added into the sums. The final sample of a run starts
// the math: a restoring divider per axis, squaring, a bit-serial square root per
// angle and a CORDIC run per angle, then the output register is loaded.
// Throughput: one sample per cycle mid-run, one run at a time through the math.
// Reset: arst_n clears sums, count, state and valid flag; count register to 10.
module accel_tilt_angle_averager_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// x_sample[15:0], y_sample[31:16], z_sample[47:32]
	input logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// avg_x, avg_y, avg_z, angle_x, angle_y, angle_z, 16 bits each from bit 0
	output logic [95:0] m_axis_tdata
);
	import ata_pkg::*;

	ata_state_t state_q, state_d;
	logic [CntW-1:0] cnt_cfg_q, taken_q;
	logic signed [SumW-1:0] sx_q, sy_q, sz_q;
	logic [1:0] ax_q;
	logic [5:0] it_q;
	logic [SumW-1:0] rem_q, quo_q, dvd_q;
	logic signed [SampleW-1:0] avg_q [3];
	logic [31:0] sq_q [3];
	logic [65:0] rad_q, rrem_q;
	logic [RootW-1:0] root_q;
	logic [AngW-1:0] ang_q [3];
	logic outv_q;
	logic [95:0] out_q;
	ata_cord_req_t req;
	logic cdone;
	logic [AngW-1:0] cang;
	logic [CntW-1:0] need;
	logic acc_in, last;
	logic signed [SumW-1:0] cur_sum;
	logic [SumW-1:0] trial;
	logic [67:0] rtrial;
	logic [SampleW-1:0] mag [3];
	logic [1:0] pa, pb;

	assign need = (cnt_cfg_q == '0) ? 8'd1 : cnt_cfg_q;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc_in = s_axis_tvalid && s_axis_tready;
	assign last = (taken_q + 8'd1) >= need;
	assign cur_sum = (ax_q == 2'd0) ? sx_q : (ax_q == 2'd1) ? sy_q : sz_q;
	assign trial = {rem_q[SumW-2:0], dvd_q[SumW-1]} - SumW'(taken_q);
	assign rtrial = {rrem_q, rad_q[65:64]} - {root_q, 2'b01};

	for (genvar k = 0; k < 3; k++) begin : g_mag
		assign mag[k] = avg_q[k][SampleW-1] ? SampleW'(-avg_q[k]) : avg_q[k];
	end

	// pick the two axes under the root for the current angle
	always_comb begin
		unique case (ax_q)
			2'd0: begin pa = 2'd1; pb = 2'd2; end
			2'd1: begin pa = 2'd0; pb = 2'd2; end
			default: begin pa = 2'd0; pb = 2'd1; end
		endcase
	end

	// advance the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc_in && last) state_d = ST_DIV;
			ST_DIV: if (it_q == 6'd24 && ax_q == 2'd2) state_d = ST_SQ;
			ST_SQ: if (ax_q == 2'd2) state_d = ST_ROOT;
			ST_ROOT: if (it_q == 6'd33) state_d = ST_CORD;
			ST_CORD: if (cdone) state_d = (ax_q == 2'd2) ? ST_DONE : ST_ROOT;
			ST_DONE: if (!outv_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// drive the CORDIC request once the root has settled
	always_comb begin
		req.start = (state_q == ST_CORD) && (it_q == 6'd34);
		if (ax_q == 2'd2) begin
			req.num = root_q;
			req.den = RootW'({mag[2], 16'd0});
			req.neg = avg_q[2][SampleW-1];
		end else begin
			req.num = RootW'({mag[ax_q], 16'd0});
			req.den = root_q;
			req.neg = avg_q[ax_q][SampleW-1];
		end
	end

	ata_cordic u_cordic (.clk, .arst_n, .req, .done(cdone), .angle(cang));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_cfg_q <= CountReset;
			taken_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
			outv_q <= 1'b0;
			ax_q <= '0;
			it_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cnt_cfg_q <= cfg_wdata;
			// load a result or drop the accepted one
			if (state_q == ST_DONE && (!outv_q || m_axis_tready)) outv_q <= 1'b1;
			else if (m_axis_tready) outv_q <= 1'b0;
			unique case (state_q)
				// accumulate one sample
				ST_IDLE: if (acc_in) begin
					sx_q <= sx_q + SumW'(signed'(s_axis_tdata[15:0]));
					sy_q <= sy_q + SumW'(signed'(s_axis_tdata[31:16]));
					sz_q <= sz_q + SumW'(signed'(s_axis_tdata[47:32]));
					taken_q <= taken_q + 8'd1;
					ax_q <= '0;
					it_q <= '0;
				end
				// restoring divide, one quotient bit per cycle
				ST_DIV: begin
					if (it_q == 6'd0) begin
						dvd_q <= cur_sum[SumW-1] ? SumW'(-cur_sum) : cur_sum;
						rem_q <= '0;
						it_q <= 6'd1;
					end else begin
						if (!trial[SumW-1]) begin
							rem_q <= trial;
							quo_q <= {quo_q[SumW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[SumW-2:0], dvd_q[SumW-1]};
							quo_q <= {quo_q[SumW-2:0], 1'b0};
						end
						dvd_q <= dvd_q << 1;
						if (it_q == 6'd24) begin
							avg_q[ax_q] <= cur_sum[SumW-1]
								? SampleW'(-{quo_q[SumW-2:0], !trial[SumW-1]})
								: SampleW'({quo_q[SumW-2:0], !trial[SumW-1]});
							it_q <= '0;
							if (ax_q == 2'd2) begin
								sx_q <= '0; sy_q <= '0; sz_q <= '0;
								taken_q <= '0;
								ax_q <= '0;
							end else begin
								ax_q <= ax_q + 2'd1;
							end
						end else begin
							it_q <= it_q + 6'd1;
						end
					end
				end
				// square magnitudes, one axis per cycle
				ST_SQ: begin
					sq_q[ax_q] <= 32'(mag[ax_q]) * 32'(mag[ax_q]);
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
				// bit-serial square root, two radicand bits per cycle
				ST_ROOT: begin
					if (it_q == 6'd0) begin
						rad_q <= {1'b0, 33'(sq_q[pa]) + 33'(sq_q[pb]), 32'd0};
						rrem_q <= '0;
						root_q <= '0;
						it_q <= 6'd1;
					end else begin
						if (!rtrial[67]) begin
							rrem_q <= rtrial[65:0];
							root_q <= {root_q[RootW-2:0], 1'b1};
						end else begin
							rrem_q <= {rrem_q[63:0], rad_q[65:64]};
							root_q <= {root_q[RootW-2:0], 1'b0};
						end
						rad_q <= rad_q << 2;
						it_q <= it_q + 6'd1;
					end
				end
				// start the angle run, then hold until it reports
				ST_CORD: begin
					if (it_q == 6'd34) begin
						it_q <= 6'd35;
					end else if (cdone) begin
						ang_q[ax_q] <= cang;
						ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
						it_q <= '0;
					end
				end
				ST_DONE: if (!outv_q || m_axis_tready) begin
					out_q <= {ang_q[2], ang_q[1], ang_q[0], avg_q[2], avg_q[1], avg_q[0]};
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = outv_q;
	assign m_axis_tdata = out_q;
endmodule

FILE: hw/rtl/ata_checker.sv
module ata_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [95:0] m_axis_tdata
);
	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	// the x angle stays within ninety degrees
	a_ang: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[63:48]) <= 16'sd23040
			&& $signed(m_axis_tdata[63:48]) >= -16'sd23040))
		else $error("angle range");
	// no sample taken on the cycle a result is loaded
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("ready during math");
endmodule

bind accel_tilt_angle_averager_top ata_checker u_ata_checker (.*);
